[src/icmp_rm_pkg.sv]
// ----------------------------------------------------------------------------
// ICMP reply matcher package
// Shared constants and types for the byte-serial ICMP reply matcher.
// ----------------------------------------------------------------------------
package icmp_rm_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 32;
    localparam int ID_W       = 16;
    localparam int POS_W      = 8;
    localparam int IHL_W      = 4;
    localparam int SEEN_W     = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = ADDR_W + BYTE_W;
    localparam int OUT_USER_W = 2;

    // ICMP type codes
    localparam logic [BYTE_W-1:0] ICMP_ECHO_REPLY    = 8'd0;
    localparam logic [BYTE_W-1:0] ICMP_TIME_EXCEEDED = 8'd11;

    // bytes between the time-exceeded header and the quoted IP header
    localparam logic [POS_W-1:0] EMBED_SKIP = 8'd8;

    // configuration register indexes (paddr[2])
    localparam logic REG_EXPECTED_ID  = 1'b0;
    localparam logic REG_EXPECTED_SEQ = 1'b1;

    // fields_seen bits
    localparam int SEEN_TYPE  = 0;
    localparam int SEEN_START = 1;
    localparam int SEEN_SEQ   = 2;

    // tuser bit positions of a result
    localparam int USER_MATCHED   = 0;
    localparam int USER_TRUNCATED = 1;

    typedef struct packed {
        logic [BYTE_W-1:0] reply_type;
        logic [ADDR_W-1:0] source_address;
    } result_data_t;

    typedef struct packed {
        logic truncated;
        logic matched;
    } result_flags_t;

endpackage

[src/icmp_reply_matcher.sv]
// ----------------------------------------------------------------------------
// ICMP reply matcher
// Parses a received IPv4 packet one byte per cycle (tlast may stall), checks
// the echo or quoted ICMP id and sequence against the configured values.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one packet byte per request, IP header first; tlast marks the
//           final byte of the packet. Bytes flow one per cycle but may stall.
//   m_axis: one result per packet, issued for the tlast byte.
//           tdata = {reply_type, source_address}, tuser = {truncated, matched}.
//   APB:    expected_id at 0x0, expected_seq at 0x4, 16 bits each, wire order
//           (first wire byte in bits 15:8). Write only while no packet is open.
// Path: a byte is held in the input register and folded into the packet
//   state there; the result of a tlast byte goes from there into the
//   result register, which drives m_axis_tvalid, once the result slot
//   is free. Throughput: one byte per cycle while no tlast byte waits
//   on a full result slot.
// Reset: clears the packet state, both expected values and both valid flags.
// Stall: while a result waits on m_axis_tready, non-final bytes keep flowing;
//   a tlast byte holds in the input register until the result slot frees,
//   and s_axis_tready is low only while such a byte waits.
// ----------------------------------------------------------------------------
module icmp_reply_matcher
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // packet bytes
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [icmp_rm_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] byte_value
    input  logic                                  s_axis_tlast,  // last_byte
    // results
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [icmp_rm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [31:0] source_address,
                                                                  // [39:32] reply_type
    output logic [icmp_rm_pkg::OUT_USER_W-1:0]    m_axis_tuser,  // [0] matched, [1] truncated
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [icmp_rm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [icmp_rm_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [icmp_rm_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [icmp_rm_pkg::ID_W-1:0] exp_id_reg;
    logic [icmp_rm_pkg::ID_W-1:0] exp_seq_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_id_reg  <= '0;
            exp_seq_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                icmp_rm_pkg::REG_EXPECTED_ID:  exp_id_reg  <= pwdata[icmp_rm_pkg::ID_W-1:0];
                icmp_rm_pkg::REG_EXPECTED_SEQ: exp_seq_reg <= pwdata[icmp_rm_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            icmp_rm_pkg::REG_EXPECTED_ID:
                prdata = {{(icmp_rm_pkg::CFG_DATA_W-icmp_rm_pkg::ID_W){1'b0}}, exp_id_reg};
            icmp_rm_pkg::REG_EXPECTED_SEQ:
                prdata = {{(icmp_rm_pkg::CFG_DATA_W-icmp_rm_pkg::ID_W){1'b0}}, exp_seq_reg};
            default:
                prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and handshake
    // ------------------------------------------------------------------
    logic                           in_valid_reg;
    logic [icmp_rm_pkg::BYTE_W-1:0] in_byte_reg;
    logic                           in_last_reg;
    logic                           out_free;
    logic                           advance;
    logic                           emit;

    // A byte advances unless it would produce a result into a full slot.
    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign emit          = advance && in_last_reg;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Packet state
    // ------------------------------------------------------------------
    logic [icmp_rm_pkg::POS_W-1:0]  pos_reg,    pos_next;
    logic [icmp_rm_pkg::IHL_W-1:0]  ihl_reg,    ihl_next;
    logic [icmp_rm_pkg::BYTE_W-1:0] otype_reg,  otype_next;
    logic [icmp_rm_pkg::POS_W-1:0]  qstart_reg, qstart_next;
    logic [icmp_rm_pkg::ADDR_W-1:0] src_reg,    src_next;
    logic [icmp_rm_pkg::ID_W-1:0]   ident_reg,  ident_next;
    logic [icmp_rm_pkg::ID_W-1:0]   seq_reg,    seq_next;
    logic [icmp_rm_pkg::BYTE_W-1:0] ftype_reg,  ftype_next;
    logic [icmp_rm_pkg::SEEN_W-1:0] seen_reg,   seen_next;

    logic [icmp_rm_pkg::BYTE_W-1:0] b;
    logic [icmp_rm_pkg::POS_W-1:0]  ostart;
    logic                           type_hit;
    logic                           te_hit;
    logic [icmp_rm_pkg::POS_W:0]    p9;
    logic [icmp_rm_pkg::POS_W:0]    s9;
    logic                           accepted;
    logic                           complete;
    logic                           match;

    assign b  = in_byte_reg;
    assign p9 = {1'b0, pos_reg};

    always_comb
    begin
        ihl_next    = ihl_reg;
        src_next    = src_reg;
        otype_next  = otype_reg;
        qstart_next = qstart_reg;
        ident_next  = ident_reg;
        seq_next    = seq_reg;
        ftype_next  = ftype_reg;
        seen_next   = seen_reg;

        // outer header length and source address
        if (pos_reg == '0)
            ihl_next = b[icmp_rm_pkg::IHL_W-1:0];
        if (pos_reg >= 8'd12 && pos_reg <= 8'd15)
            src_next = {src_reg[icmp_rm_pkg::ADDR_W-icmp_rm_pkg::BYTE_W-1:0], b};

        // outer ICMP type at 4*IHL
        ostart   = {2'b00, ihl_next, 2'b00};
        type_hit = !seen_reg[icmp_rm_pkg::SEEN_TYPE] && (pos_reg == ostart);
        if (type_hit)
        begin
            otype_next = b;
            seen_next[icmp_rm_pkg::SEEN_TYPE] = 1'b1;
            if (b == icmp_rm_pkg::ICMP_ECHO_REPLY)
            begin
                qstart_next = ostart;
                seen_next[icmp_rm_pkg::SEEN_START] = 1'b1;
            end
        end

        // time exceeded: quoted IP header length gives the quoted ICMP start
        te_hit = seen_next[icmp_rm_pkg::SEEN_TYPE]
              && (otype_next == icmp_rm_pkg::ICMP_TIME_EXCEEDED)
              && !seen_next[icmp_rm_pkg::SEEN_START]
              && (pos_reg == ostart + icmp_rm_pkg::EMBED_SKIP);
        if (te_hit)
        begin
            qstart_next = pos_reg + {2'b00, b[icmp_rm_pkg::IHL_W-1:0], 2'b00};
            seen_next[icmp_rm_pkg::SEEN_START] = 1'b1;
        end

        // checked ICMP header: type, id, sequence (compared without wrap)
        s9 = {1'b0, qstart_next};
        if (seen_next[icmp_rm_pkg::SEEN_START])
        begin
            if (p9 == s9)
                ftype_next = b;
            if (p9 == s9 + 9'd4)
                ident_next[15:8] = b;
            if (p9 == s9 + 9'd5)
                ident_next[7:0] = b;
            if (p9 == s9 + 9'd6)
                seq_next[15:8] = b;
            if (p9 == s9 + 9'd7)
            begin
                seq_next[7:0] = b;
                seen_next[icmp_rm_pkg::SEEN_SEQ] = 1'b1;
            end
        end

        // saturating byte counter
        pos_next = (pos_reg == '1) ? pos_reg : pos_reg + 8'd1;

        // verdict for the final byte
        accepted = seen_next[icmp_rm_pkg::SEEN_TYPE]
                && (otype_next == icmp_rm_pkg::ICMP_ECHO_REPLY
                 || otype_next == icmp_rm_pkg::ICMP_TIME_EXCEEDED);
        complete = (pos_reg >= 8'd15) && seen_next[icmp_rm_pkg::SEEN_TYPE]
                && (!accepted || seen_next[icmp_rm_pkg::SEEN_SEQ]);
        match    = complete && accepted
                && (ident_next == exp_id_reg) && (seq_next == exp_seq_reg);
    end

    // Advance the state per byte; drop it all after the final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            ihl_reg    <= '0;
            otype_reg  <= '0;
            qstart_reg <= '0;
            src_reg    <= '0;
            ident_reg  <= '0;
            seq_reg    <= '0;
            ftype_reg  <= '0;
            seen_reg   <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                pos_reg    <= '0;
                ihl_reg    <= '0;
                otype_reg  <= '0;
                qstart_reg <= '0;
                src_reg    <= '0;
                ident_reg  <= '0;
                seq_reg    <= '0;
                ftype_reg  <= '0;
                seen_reg   <= '0;
            end
            else
            begin
                pos_reg    <= pos_next;
                ihl_reg    <= ihl_next;
                otype_reg  <= otype_next;
                qstart_reg <= qstart_next;
                src_reg    <= src_next;
                ident_reg  <= ident_next;
                seq_reg    <= seq_next;
                ftype_reg  <= ftype_next;
                seen_reg   <= seen_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                        out_valid_reg, out_valid_next;
    icmp_rm_pkg::result_data_t   out_data_reg;
    icmp_rm_pkg::result_flags_t  out_flags_reg;

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.source_address <= src_next;
            out_data_reg.reply_type     <= match ? ftype_next : '0;
            out_flags_reg.matched       <= match;
            out_flags_reg.truncated     <= !complete;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flags_reg;

endmodule

[src/icmp_rm_checker.sv]
// ----------------------------------------------------------------------------
// ICMP reply matcher checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module icmp_rm_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               s_axis_tlast,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [icmp_rm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [icmp_rm_pkg::OUT_USER_W-1:0] m_axis_tuser
);

    // A stalled result holds.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // A match is never reported for a truncated packet.
    a_match_complete: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[icmp_rm_pkg::USER_MATCHED]
                         && m_axis_tuser[icmp_rm_pkg::USER_TRUNCATED]))
        else $error("match flagged on truncated packet");

    // The reply type reads zero unless matched.
    a_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[icmp_rm_pkg::USER_MATCHED]
        |-> m_axis_tdata[icmp_rm_pkg::OUT_DATA_W-1:icmp_rm_pkg::ADDR_W] == '0)
        else $error("reply type set without a match");

    // Unstalled, a final byte yields a result via the input and result registers.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast && m_axis_tready
        ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("no result for final byte");

endmodule

bind icmp_reply_matcher icmp_rm_checker u_icmp_rm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[verif/tb_icmp_reply_matcher.sv]
// ----------------------------------------------------------------------------
// ICMP reply matcher testbench
// Streams IPv4 packets byte by byte into the matcher and runs them through a
// behavioral model of the parser kept in a small scoreboard. Each packet
// result on the output stream is checked against that model, field by
// field. The packets are echo replies and time-exceeded packets with both
// right and wrong id/sequence values, other ICMP types, noise, cut-short
// packets, odd header lengths and packets past the byte-position
// saturation. Random gaps on both streams move idle cycles across every
// phase of the parse.
// ----------------------------------------------------------------------------
module tb_icmp_reply_matcher;

    import icmp_rm_pkg::*;

    // one expected packet result
    typedef struct packed {
        logic              matched;
        logic              truncated;
        logic [BYTE_W-1:0] reply_type;
        logic [ADDR_W-1:0] source_address;
    } reply_t;

    // kinds of generated packets
    typedef enum int { PKT_ECHO, PKT_TIME_EXCEEDED, PKT_OTHER, PKT_NOISE } pkt_kind_t;

    // idle patterns for either stream
    typedef enum int { IDLE_NONE, IDLE_FULL, IDLE_RARE } idle_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: parses accepted bytes the way the matcher should and
    // holds the packet results still owed by the block.
    // ------------------------------------------------------------------------
    class reply_scoreboard;
        reply_t             pending_replies[$];
        logic [ID_W-1:0]    want_id;
        logic [ID_W-1:0]    want_seq;
        // per-packet parse state
        logic [POS_W-1:0]   pos;
        logic [IHL_W-1:0]   outer_ihl;
        logic [BYTE_W-1:0]  outer_type;
        logic [IHL_W-1:0]   inner_ihl;
        logic [POS_W-1:0]   check_start;
        logic [ADDR_W-1:0]  source;
        logic [ID_W-1:0]    ident;
        logic [ID_W-1:0]    seqn;
        logic [BYTE_W-1:0]  final_type;
        logic [SEEN_W-1:0]  seen;
        int                 mismatches = 0;
        int                 results = 0;
        int                 hits = 0;
        int                 cut_short = 0;

        function new();
            want_id  = '0;
            want_seq = '0;
            clear_packet();
        endfunction

        function void clear_packet();
            pos         = '0;
            outer_ihl   = '0;
            outer_type  = '0;
            inner_ihl   = '0;
            check_start = '0;
            source      = '0;
            ident       = '0;
            seqn        = '0;
            final_type  = '0;
            seen        = '0;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        // fold one accepted byte into the parse; owe a result on the last one
        function void take_byte(logic [BYTE_W-1:0] b, logic last);
            int     p;
            int     ostart;
            int     s;
            logic   accepted;
            logic   complete;
            logic   hit;
            reply_t r;
            p = pos;
            if (p == 0)
                outer_ihl = b[IHL_W-1:0];
            if (p >= 12 && p <= 15)
                source = {source[ADDR_W-9:0], b};
            ostart = 4 * outer_ihl;
            if (!seen[SEEN_TYPE] && p == ostart)
            begin
                outer_type      = b;
                seen[SEEN_TYPE] = 1'b1;
                if (b == ICMP_ECHO_REPLY)
                begin
                    check_start      = POS_W'(ostart);
                    seen[SEEN_START] = 1'b1;
                end
            end
            if (seen[SEEN_TYPE] && outer_type == ICMP_TIME_EXCEEDED && !seen[SEEN_START]
                && p == ostart + int'(EMBED_SKIP))
            begin
                inner_ihl        = b[IHL_W-1:0];
                check_start      = POS_W'(p + 4 * inner_ihl);
                seen[SEEN_START] = 1'b1;
            end
            if (seen[SEEN_START])
            begin
                s = check_start;
                if (p == s)
                    final_type = b;
                if (p == s + 4)
                    ident[15:8] = b;
                if (p == s + 5)
                    ident[7:0] = b;
                if (p == s + 6)
                    seqn[15:8] = b;
                if (p == s + 7)
                begin
                    seqn[7:0]      = b;
                    seen[SEEN_SEQ] = 1'b1;
                end
            end
            if (pos != '1)
                pos++;
            if (!last)
                return;
            accepted = seen[SEEN_TYPE] &&
                       (outer_type == ICMP_ECHO_REPLY || outer_type == ICMP_TIME_EXCEEDED);
            complete = p >= 15 && seen[SEEN_TYPE] && (!accepted || seen[SEEN_SEQ]);
            hit      = complete && accepted && ident == want_id && seqn == want_seq;
            r.matched        = hit;
            r.truncated      = !complete;
            r.reply_type     = hit ? final_type : '0;
            r.source_address = source;
            pending_replies.push_back(r);
            clear_packet();
        endfunction

        // compare one accepted result with the oldest owed one
        task check_result(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
            result_data_t  d;
            result_flags_t f;
            reply_t        r;
            d = data;
            f = user;
            results++;
            if (f.matched)
                hits++;
            if (f.truncated)
                cut_short++;
            if (pending_replies.size() == 0)
            begin
                report($sformatf("result with none owed: data 0x%h user 0x%h", data, user));
                return;
            end
            r = pending_replies.pop_front();
            if (f.matched !== r.matched)
                report($sformatf("matched got %b want %b", f.matched, r.matched));
            if (f.truncated !== r.truncated)
                report($sformatf("truncated got %b want %b", f.truncated, r.truncated));
            if (d.source_address !== r.source_address)
                report($sformatf("source_address got 0x%h want 0x%h",
                                 d.source_address, r.source_address));
            if (d.reply_type !== r.reply_type)
                report($sformatf("reply_type got 0x%h want 0x%h", d.reply_type, r.reply_type));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata;   // [7:0] byte_value
    logic                  s_axis_tlast;   // last_byte
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [31:0] source_address, [39:32] reply_type
    logic [OUT_USER_W-1:0] m_axis_tuser;   // [0] matched, [1] truncated
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    icmp_reply_matcher dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    reply_scoreboard sb;
    logic [BYTE_W-1:0] pkt[$];
    idle_mode_t        feed_mode;
    idle_mode_t        sink_mode;
    int                bytes_sent;
    int                packets_sent;
    logic              out_of_reset;

    // 10-unit clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // draw the idle cycles in front of one request
    function automatic int draw_gap(idle_mode_t mode);
        case (mode)
            IDLE_FULL: return $urandom_range(0, 15);
            IDLE_RARE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
            default:   return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus drivers. All of them enter and leave at a falling edge.
    // ------------------------------------------------------------------------

    // offer one byte, hold it until taken, then note it
    task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
        int gap;
        gap = draw_gap(feed_mode);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        packets_sent++;
    endtask

    // setup then access phase register write; the model takes the value on the same edge
    task automatic write_reg(logic reg_sel, logic [ID_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {reg_sel, 2'b00};
        // junk in the upper bits must be dropped
        pwdata  <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_sel == REG_EXPECTED_ID)
            sb.want_id = value;
        else
            sb.want_seq = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait out every owed result plus the pipeline before touching registers
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(negedge clk);
    endtask

    // set a byte only when the packet is long enough to hold it
    function automatic void put(int idx, logic [BYTE_W-1:0] value);
        if (idx < pkt.size())
            pkt[idx] = value;
    endfunction

    // id or sequence for a checked header: mostly right, sometimes near or far off
    function automatic logic [ID_W-1:0] pick_key(logic [ID_W-1:0] want);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return want;
        else if (pick < 9)
            return want ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
        return ID_W'($urandom);
    endfunction

    // build one packet into pkt
    task automatic build_packet();
        pkt_kind_t          kind;
        int                 pick;
        int                 ihl;
        int                 inner;
        int                 ostart;
        int                 s;
        int                 need;
        int                 len;
        logic [BYTE_W-1:0]  other_type;
        logic [ID_W-1:0]    key;
        pick = $urandom_range(0, 99);
        kind = (pick < 45) ? PKT_ECHO : (pick < 80) ? PKT_TIME_EXCEEDED :
               (pick < 92) ? PKT_OTHER : PKT_NOISE;
        // odd header lengths, short ones included, a quarter of the time
        ihl    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
        inner  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
        ostart = 4 * ihl;
        s      = ostart;
        case (kind)
            PKT_ECHO:          need = s + 8;
            PKT_TIME_EXCEEDED:
            begin
                s    = ostart + int'(EMBED_SKIP) + 4 * inner;
                need = s + 8;
            end
            PKT_OTHER:         need = ostart + 1;
            default:           need = $urandom_range(1, 40);
        endcase
        if (need < 16)
            need = 16;
        len = need + $urandom_range(0, 12);
        // cut short, at most to the end of the required fields
        if ($urandom_range(0, 6) == 0)
            len = $urandom_range(1, need);
        // run past the position counter's saturation
        if ($urandom_range(0, 60) == 0)
            len = $urandom_range(256, 300);
        pkt.delete();
        for (int i = 0; i < len; i++)
            pkt.push_back(BYTE_W'($urandom));
        if (kind == PKT_NOISE)
            return;
        pkt[0] = {4'($urandom), 4'(ihl)};
        case (kind)
            PKT_ECHO:          put(ostart, ICMP_ECHO_REPLY);
            PKT_TIME_EXCEEDED:
            begin
                put(ostart, ICMP_TIME_EXCEEDED);
                put(ostart + int'(EMBED_SKIP), {4'($urandom), 4'(inner)});
                // quoted header is an echo request about half the time
                put(s, ($urandom_range(0, 1) == 0) ? 8'd8 : 8'($urandom));
            end
            default:
            begin
                do
                    other_type = BYTE_W'($urandom);
                while (other_type == ICMP_ECHO_REPLY || other_type == ICMP_TIME_EXCEEDED);
                put(ostart, other_type);
            end
        endcase
        if (kind != PKT_OTHER)
        begin
            key = pick_key(sb.want_id);
            put(s + 4, key[15:8]);
            put(s + 5, key[7:0]);
            key = pick_key(sb.want_seq);
            put(s + 6, key[15:8]);
            put(s + 7, key[7:0]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random tready gaps, check each accepted result.
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        wait (out_of_reset);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(sink_mode);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [ID_W-1:0] id_val;
        logic [ID_W-1:0] seq_val;
        int              phase_start;
        sb            = new();
        bytes_sent    = 0;
        packets_sent  = 0;
        out_of_reset  = 1'b0;
        feed_mode     = IDLE_NONE;
        sink_mode     = IDLE_NONE;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n        <= 1'b1;
        out_of_reset  = 1'b1;
        @(negedge clk);

        // Directed packets against the reset values (both keys zero).
        // A lone all-ones byte: nothing captured, truncated.
        pkt = '{8'hFF};
        send_packet();
        // Zero header length: byte 0 is also the ICMP type (echo reply), the
        // id and sequence sit at bytes 4..7 and the source at 12..15.
        pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'hC0, 8'hA8, 8'h01, 8'hFF};
        send_packet();
        // Header cut off before the source address.
        pkt = '{8'h45, 8'h00, 8'h00, 8'h1C, 8'hFF};
        send_packet();
        s_axis_tvalid <= 1'b0;
        drain();

        // Random phases, one register setting each, extremes first.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin id_val = 16'hFFFF; seq_val = 16'hFFFF; end
                1: begin id_val = 16'h0000; seq_val = 16'hFFFF; end
                2: begin id_val = 16'hFFFF; seq_val = 16'h0000; end
                default:
                begin
                    id_val  = ID_W'($urandom);
                    seq_val = ID_W'($urandom);
                end
            endcase
            write_reg(REG_EXPECTED_ID, id_val);
            write_reg(REG_EXPECTED_SEQ, seq_val);
            // first phase runs both streams flat out
            feed_mode = (phase == 0) ? IDLE_NONE : idle_mode_t'($urandom_range(0, 2));
            sink_mode = (phase == 0) ? IDLE_NONE : idle_mode_t'($urandom_range(0, 2));
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 360)
            begin
                build_packet();
                send_packet();
            end
            // drop valid at the step the last byte left off
            s_axis_tvalid <= 1'b0;
            drain();
        end

        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("ran %0d packets (%0d bytes) over six key settings", packets_sent, bytes_sent);
        $display("saw %0d results: %0d matched, %0d truncated",
                 sb.results, sb.hits, sb.cut_short);
        if (sb.mismatches == 0)
            $display("icmp_reply_matcher regression: pass");
        else
            $display("icmp_reply_matcher regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with every gap at its maximum.
    initial
    begin
        #3000000;
        $display("timeout waiting on the matcher");
        $display("icmp_reply_matcher regression: fail");
        $finish;
    end

endmodule

[sim.f]
src/icmp_rm_pkg.sv
src/icmp_reply_matcher.sv
src/icmp_rm_checker.sv
verif/tb_icmp_reply_matcher.sv
